@@ hw/rtl/btc_pkg.sv @@
// Package for the transaction classifier: parse phases, tag and flow codes, field sizes.
package btc_pkg;

  // Byte counter and length register width
  localparam int CNT_W = 32;

  localparam logic [7:0] JSON_OPEN = 8'h7B;

  // Fixed field sizes in bytes
  localparam logic [5:0] KEY_SIZE    = 6'd33;
  localparam logic [5:0] NONCE_SIZE  = 6'd8;
  localparam logic [5:0] HASH_SIZE   = 6'd32;
  localparam logic [5:0] AMOUNT_SIZE = 6'd16;
  localparam logic [5:0] BYTE_SIZE   = 6'd1;
  localparam logic [5:0] NO_SIZE     = 6'd0;

  // Action type codes
  localparam logic [7:0] ACT_FCALL     = 8'd2;
  localparam logic [7:0] ACT_TRANSFER  = 8'd3;
  localparam logic [7:0] ACT_ADDKEY    = 8'd5;
  localparam logic [7:0] ACT_LAST_KIND = 8'd7;

  typedef enum logic [4:0] {
    P_SLEN     = 5'd0,
    P_SIGNER   = 5'd1,
    P_KEY      = 5'd2,
    P_NONCE    = 5'd3,
    P_RLEN     = 5'd4,
    P_RECV     = 5'd5,
    P_HASH     = 5'd6,
    P_ACNT     = 5'd7,
    P_ATYPE    = 5'd8,
    P_AMOUNT   = 5'd9,
    P_MLEN     = 5'd10,
    P_METHOD   = 5'd11,
    P_ALEN     = 5'd12,
    P_ARGS     = 5'd13,
    P_GAS      = 5'd14,
    P_DEPOSIT  = 5'd15,
    P_KTYPE    = 5'd16,
    P_KDATA    = 5'd17,
    P_KNONCE   = 5'd18,
    P_PERM     = 5'd19,
    P_HASALLOW = 5'd20,
    P_ALLOW    = 5'd21,
    P_PRLEN    = 5'd22,
    P_PRECV    = 5'd23
  } phase_t;

  typedef enum logic [3:0] {
    TAG_NONE      = 4'd0,
    TAG_SIGNER    = 4'd1,
    TAG_RECEIVER  = 4'd2,
    TAG_METHOD    = 4'd3,
    TAG_JSON_ARGS = 4'd4,
    TAG_AMOUNT    = 4'd5,
    TAG_DEPOSIT   = 4'd6,
    TAG_ALLOWANCE = 4'd7,
    TAG_PERM_RECV = 4'd8
  } tag_t;

  typedef enum logic [2:0] {
    FLOW_GENERIC  = 3'd0,
    FLOW_TRANSFER = 3'd1,
    FLOW_FCALL    = 3'd2,
    FLOW_CALL_KEY = 3'd3,
    FLOW_FULL_KEY = 3'd4,
    FLOW_PARSE    = 3'd5
  } flow_t;

  // Size of a fixed-length field phase; zero for phases that have none
  function automatic logic [5:0] field_size(input phase_t p);
    logic [5:0] s;
    case (p)
      P_KEY:     s = KEY_SIZE;
      P_NONCE:   s = NONCE_SIZE;
      P_HASH:    s = HASH_SIZE;
      P_AMOUNT:  s = AMOUNT_SIZE;
      P_GAS:     s = NONCE_SIZE;
      P_DEPOSIT: s = AMOUNT_SIZE;
      P_KTYPE:   s = BYTE_SIZE;
      P_KDATA:   s = HASH_SIZE;
      P_KNONCE:  s = NONCE_SIZE;
      P_ALLOW:   s = AMOUNT_SIZE;
      default:   s = NO_SIZE;
    endcase
    return s;
  endfunction

  // Display tag of a fixed-length field phase
  function automatic tag_t field_tag_of(input phase_t p);
    tag_t t;
    case (p)
      P_AMOUNT:  t = TAG_AMOUNT;
      P_DEPOSIT: t = TAG_DEPOSIT;
      P_ALLOW:   t = TAG_ALLOWANCE;
      default:   t = TAG_NONE;
    endcase
    return t;
  endfunction

endpackage

@@ hw/rtl/borsh_transaction_classifier.sv @@
// Streaming byte-level classifier of serialized transactions.
//
//   channel | dir | handshake            | payload
//   in_     | in  | in_tvalid/in_tready  | tdata = data_byte, tlast = last_byte
//   out_    | out | out_tvalid/out_tready| tdata = field_tag, done_res, flow
//
// One byte per cycle while the output is not stalled; each byte is held in the input
// register and then registered in the output register. The rate is set by the single
// parse-state update per byte: a 32-bit counter increment and compare against the field
// length. Reset clears the parse state and both valid flags. A stalled output
// holds its result and the input register, and in_tready drops only when both are full.
module borsh_transaction_classifier (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] data_byte
  input  logic       in_tlast,   // last_byte
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata   // [3:0] field_tag, [4] done_res, [7:5] flow
);

  localparam int CW = btc_pkg::CNT_W;

  // Input register
  logic       in_valid_r;
  logic [7:0] in_byte_r;
  logic       in_last_r;

  // Output register
  logic       out_valid_r;
  logic [7:0] out_data_r;
  logic [7:0] out_data_nxt;

  // Parse state
  btc_pkg::phase_t phase_r, phase_nxt;
  logic [CW-1:0]   cnt_r, cnt_nxt;
  logic [CW-1:0]   len_r, len_nxt;
  logic            fin_r, fin_nxt;
  logic            json_r, json_nxt;

  logic            advance;
  logic [CW-1:0]   cnt_inc;
  logic [CW-1:0]   len_acc;
  logic            json_now;
  btc_pkg::tag_t   tag;
  logic            done;
  btc_pkg::flow_t  flow;
  logic [5:0]      size;

  assign advance   = in_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !in_valid_r || advance;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  assign cnt_inc = cnt_r + CW'(1);
  assign size    = btc_pkg::field_size(phase_r);

  // Little-endian accumulation of a 32-bit length prefix
  always_comb begin
    len_acc = len_r;
    case (cnt_r[1:0])
      2'd0:    len_acc[7:0]   = len_r[7:0]   | in_byte_r;
      2'd1:    len_acc[15:8]  = len_r[15:8]  | in_byte_r;
      2'd2:    len_acc[23:16] = len_r[23:16] | in_byte_r;
      default: len_acc[31:24] = len_r[31:24] | in_byte_r;
    endcase
  end

  // Args are JSON when the first args byte opens an object
  assign json_now = (cnt_r == '0) ? (in_byte_r == btc_pkg::JSON_OPEN) : json_r;

  // Next parse state and result for the byte in the input register
  always_comb begin
    phase_nxt = phase_r;
    cnt_nxt   = cnt_r;
    len_nxt   = len_r;
    fin_nxt   = fin_r;
    json_nxt  = json_r;
    tag       = btc_pkg::TAG_NONE;
    done      = 1'b0;
    flow      = btc_pkg::FLOW_GENERIC;

    if (!fin_r) begin
      case (phase_r)
        btc_pkg::P_SLEN, btc_pkg::P_RLEN, btc_pkg::P_ACNT,
        btc_pkg::P_MLEN, btc_pkg::P_ALEN, btc_pkg::P_PRLEN: begin
          len_nxt = len_acc;
          cnt_nxt = cnt_inc;
          if (cnt_inc >= CW'(4)) begin
            cnt_nxt = '0;
            case (phase_r)
              btc_pkg::P_SLEN: begin
                phase_nxt = (len_acc != '0) ? btc_pkg::P_SIGNER : btc_pkg::P_KEY;
              end
              btc_pkg::P_RLEN: begin
                phase_nxt = (len_acc != '0) ? btc_pkg::P_RECV : btc_pkg::P_HASH;
              end
              btc_pkg::P_MLEN: begin
                if (len_acc != '0) begin
                  phase_nxt = btc_pkg::P_METHOD;
                end else begin
                  phase_nxt = btc_pkg::P_ALEN;
                  len_nxt   = '0;
                end
              end
              btc_pkg::P_ALEN: begin
                phase_nxt = (len_acc != '0) ? btc_pkg::P_ARGS : btc_pkg::P_GAS;
              end
              btc_pkg::P_PRLEN: begin
                if (len_acc != '0) begin
                  phase_nxt = btc_pkg::P_PRECV;
                end else begin
                  cnt_nxt = cnt_inc;
                  done    = 1'b1;
                  flow    = btc_pkg::FLOW_CALL_KEY;
                  fin_nxt = 1'b1;
                end
              end
              default: begin
                // action count: only a single action is classified
                if (len_acc != CW'(1)) begin
                  cnt_nxt = cnt_inc;
                  done    = 1'b1;
                  flow    = btc_pkg::FLOW_GENERIC;
                  fin_nxt = 1'b1;
                end else begin
                  phase_nxt = btc_pkg::P_ATYPE;
                end
              end
            endcase
          end
        end

        btc_pkg::P_SIGNER, btc_pkg::P_RECV, btc_pkg::P_METHOD,
        btc_pkg::P_ARGS, btc_pkg::P_PRECV: begin
          case (phase_r)
            btc_pkg::P_SIGNER: tag = btc_pkg::TAG_SIGNER;
            btc_pkg::P_RECV:   tag = btc_pkg::TAG_RECEIVER;
            btc_pkg::P_METHOD: tag = btc_pkg::TAG_METHOD;
            btc_pkg::P_PRECV:  tag = btc_pkg::TAG_PERM_RECV;
            default: begin
              json_nxt = json_now;
              tag      = json_now ? btc_pkg::TAG_JSON_ARGS : btc_pkg::TAG_NONE;
            end
          endcase
          cnt_nxt = cnt_inc;
          if (cnt_inc >= len_r) begin
            case (phase_r)
              btc_pkg::P_SIGNER: begin
                phase_nxt = btc_pkg::P_KEY;
                cnt_nxt   = '0;
              end
              btc_pkg::P_RECV: begin
                phase_nxt = btc_pkg::P_HASH;
                cnt_nxt   = '0;
              end
              btc_pkg::P_METHOD: begin
                phase_nxt = btc_pkg::P_ALEN;
                cnt_nxt   = '0;
                len_nxt   = '0;
              end
              btc_pkg::P_ARGS: begin
                phase_nxt = btc_pkg::P_GAS;
                cnt_nxt   = '0;
              end
              default: begin
                done    = 1'b1;
                flow    = btc_pkg::FLOW_CALL_KEY;
                fin_nxt = 1'b1;
              end
            endcase
          end
        end

        btc_pkg::P_ATYPE: begin
          if (in_byte_r == btc_pkg::ACT_TRANSFER) begin
            phase_nxt = btc_pkg::P_AMOUNT;
            cnt_nxt   = '0;
          end else if (in_byte_r == btc_pkg::ACT_FCALL) begin
            phase_nxt = btc_pkg::P_MLEN;
            cnt_nxt   = '0;
            len_nxt   = '0;
          end else if (in_byte_r == btc_pkg::ACT_ADDKEY) begin
            phase_nxt = btc_pkg::P_KTYPE;
            cnt_nxt   = '0;
          end else begin
            done    = 1'b1;
            flow    = (in_byte_r <= btc_pkg::ACT_LAST_KIND) ? btc_pkg::FLOW_GENERIC
                                                            : btc_pkg::FLOW_PARSE;
            fin_nxt = 1'b1;
          end
        end

        btc_pkg::P_PERM: begin
          if (in_byte_r == 8'd0) begin
            phase_nxt = btc_pkg::P_HASALLOW;
            cnt_nxt   = '0;
          end else begin
            done    = 1'b1;
            flow    = btc_pkg::FLOW_FULL_KEY;
            fin_nxt = 1'b1;
          end
        end

        btc_pkg::P_HASALLOW: begin
          cnt_nxt = '0;
          if (in_byte_r != 8'd0) begin
            phase_nxt = btc_pkg::P_ALLOW;
          end else begin
            phase_nxt = btc_pkg::P_PRLEN;
            len_nxt   = '0;
          end
        end

        default: begin
          // fixed-length fields
          tag = btc_pkg::field_tag_of(phase_r);
          if (size == btc_pkg::NO_SIZE) begin
            tag     = btc_pkg::TAG_NONE;
            done    = 1'b1;
            flow    = btc_pkg::FLOW_PARSE;
            fin_nxt = 1'b1;
          end else begin
            cnt_nxt = cnt_inc;
            if (cnt_inc >= CW'(size)) begin
              cnt_nxt = '0;
              case (phase_r)
                btc_pkg::P_KEY:    phase_nxt = btc_pkg::P_NONCE;
                btc_pkg::P_NONCE: begin
                  phase_nxt = btc_pkg::P_RLEN;
                  len_nxt   = '0;
                end
                btc_pkg::P_HASH: begin
                  phase_nxt = btc_pkg::P_ACNT;
                  len_nxt   = '0;
                end
                btc_pkg::P_AMOUNT: begin
                  cnt_nxt = cnt_inc;
                  done    = 1'b1;
                  flow    = btc_pkg::FLOW_TRANSFER;
                  fin_nxt = 1'b1;
                end
                btc_pkg::P_GAS:    phase_nxt = btc_pkg::P_DEPOSIT;
                btc_pkg::P_DEPOSIT: begin
                  cnt_nxt = cnt_inc;
                  done    = 1'b1;
                  flow    = btc_pkg::FLOW_FCALL;
                  fin_nxt = 1'b1;
                end
                btc_pkg::P_KTYPE:  phase_nxt = btc_pkg::P_KDATA;
                btc_pkg::P_KDATA:  phase_nxt = btc_pkg::P_KNONCE;
                btc_pkg::P_KNONCE: phase_nxt = btc_pkg::P_PERM;
                default: begin
                  phase_nxt = btc_pkg::P_PRLEN;
                  len_nxt   = '0;
                end
              endcase
            end
          end
        end
      endcase

      // transaction ended before it was classified
      if (!done && in_last_r) begin
        done = 1'b1;
        flow = btc_pkg::FLOW_PARSE;
      end
    end

    // last byte rearms the parser
    if (in_last_r) begin
      phase_nxt = btc_pkg::P_SLEN;
      cnt_nxt   = '0;
      len_nxt   = '0;
      fin_nxt   = 1'b0;
      json_nxt  = 1'b0;
    end

    out_data_nxt = {flow, done, tag};
  end

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      in_byte_r <= in_tdata;
      in_last_r <= in_tlast;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data_r <= out_data_nxt;
    end
  end

  // Parse state, updated once per byte
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= btc_pkg::P_SLEN;
      cnt_r   <= '0;
      len_r   <= '0;
      fin_r   <= 1'b0;
      json_r  <= 1'b0;
    end else if (advance) begin
      phase_r <= phase_nxt;
      cnt_r   <= cnt_nxt;
      len_r   <= len_nxt;
      fin_r   <= fin_nxt;
      json_r  <= json_nxt;
    end
  end

endmodule
